FILE: rtl/cbc_pkg.sv
// Shared types, constants and register codes for the collision barrier chain.
package cbc_pkg;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        thrust;
      logic [47:0]        rot_row0;
      logic [47:0]        rot_row1;
      logic [47:0]        rot_row2;
   } cbc_req_type;

   typedef struct packed {
      logic signed [63:0] barrier_value;
      logic signed [63:0] psi_one;
      logic signed [63:0] psi_two;
      logic signed [63:0] lie_drift;
      logic signed [63:0] coef_thrust_rate;
      logic signed [63:0] coef_rate_one;
      logic signed [63:0] coef_rate_two;
      logic signed [63:0] body_rel_x;
      logic signed [63:0] body_rel_y;
      logic signed [63:0] body_rel_z;
      logic               saturated;
   } cbc_rsp_type;

   // Q32.32 number with its clip mark
   typedef struct packed {
      logic signed [63:0] value;
      logic               clip;
   } cbc_num_type;

   localparam logic [63:0] Q_TWO     = 64'h0000_0002_0000_0000;
   localparam logic [63:0] Q_SIX     = 64'h0000_0006_0000_0000;
   localparam logic [63:0] Q_GRAVITY = 64'd42133629174;
   localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;

   localparam logic [2:0] CSR_OBS_X    = 3'd0;
   localparam logic [2:0] CSR_OBS_Y    = 3'd1;
   localparam logic [2:0] CSR_OBS_Z    = 3'd2;
   localparam logic [2:0] CSR_CLEAR    = 3'd3;
   localparam logic [2:0] CSR_GAIN_1   = 3'd4;
   localparam logic [2:0] CSR_GAIN_2   = 3'd5;
   localparam logic [2:0] CSR_INV_MASS = 3'd6;
   localparam logic [2:0] CSR_CYL      = 3'd7;

   // edges from start transfer to strobe transfer
   localparam int RSP_LAT = 33;

endpackage

FILE: rtl/collision_barrier_chain_core.sv
// Top level of the collision barrier chain: pipelined second-order barrier terms.
//
// Usage notes
// - Input: drive req_data and raise start; a transfer happens on each rising edge
//   with start high and busy low. busy is only high while reset is held, so a new
//   state sample can be taken every cycle.
// - Result: rsp_strobe is high for exactly one cycle with rsp_data; that edge is the
//   transfer. There is no back-pressure on this side, so results are simply
//   registered at the end of the pipe and shown once.
// - Throughput is one item per cycle, fixed. The depth is set by the longest chain:
//   thrust*inv_mass -> acceleration -> rel.a -> ddh -> dpsi1 -> lie term, five
//   multiplier passes of five stages each plus the entry register, the a_z and dot
//   product sums and the saturating adds.
// - Config: csr_valid/csr_ready/csr_index/csr_data, always ready. Write only while no
//   item is in flight; registers are read live by each stage that uses them.
// - Reset (synchronous, active high) empties the pipe and restores register defaults.
// - saturated flags any clipped step of that item.
module collision_barrier_chain_core import cbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  cbc_req_type req_data,
   output logic        rsp_strobe,
   output cbc_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration
   logic signed [31:0] obs_x_ff, obs_y_ff, obs_z_ff;
   logic [30:0]        clr_ff, g1_ff, g2_ff, im_ff;
   logic               cyl_ff;
   logic [63:0]        dmin_q, im_q, g1_q, g2_q, g1x2_q, im2_q;

   // entry stage (time 0)
   logic [32:0] dx_in, dy_in, dz_in;
   logic [63:0] rel_in [0:2];
   logic [63:0] vf_in  [0:2];
   logic [63:0] vp_in  [0:2];
   logic [47:0] row_in [0:2];
   logic [63:0] rel_ff [0:2];
   logic [63:0] vf_ff  [0:2];
   logic [63:0] vp_ff  [0:2];
   logic [63:0] rot_ff [0:2][0:2];
   logic [63:0] thr_ff;
   logic        vld_ff [0:31];

   // delay lines, first index is the time a value is valid (acc_d_ff is indexed by axis)
   logic [63:0] rel_d_ff  [1:11][0:2];
   logic [63:0] vp_d_ff   [1:11][0:2];
   logic [63:0] rc2_d_ff  [1:5][0:2];
   logic [63:0] dd_d_ff   [6:7];
   logic [63:0] tm_d_ff   [6:7];
   logic [63:0] acc_d_ff  [0:1];
   logic [63:0] accv      [0:2];
   logic [63:0] dh_d_ff;
   logic [63:0] g1dh_d_ff [18:24];
   logic [63:0] twovv_d_ff[13:23];
   logic [63:0] g1vv_d_ff [13:23];
   logic [63:0] g1ra_d_ff;
   logic [63:0] g2p1_d_ff [20:25];
   logic [63:0] ls2_d_ff  [26:30];
   logic [63:0] h_d_ff    [9:31];
   logic [63:0] psi1_d_ff [15:31];
   logic [63:0] psi2_d_ff [27:31];
   logic [63:0] ctau_d_ff [13:31];
   logic [63:0] cw1_d_ff  [13:31];
   logic [63:0] cw2_d_ff  [13:31];
   logic [63:0] rt_d_ff   [8:31][0:2];
   logic [63:0] k2tm;

   // arithmetic results
   cbc_num_type rr [0:2], rv [0:2], vv [0:2], rtp [0:2][0:2];
   cbc_num_type acc [0:2], rap [0:2], vap [0:2];
   cbc_num_type dd, tm, rrs, rvs, vvs, rts [0:2], h, acc2s, ras, vas;
   cbc_num_type dh, twovv, g1vv, cw1, cw2, ctau, g1h, psi1, g1dh, g2p1;
   cbc_num_type twora, sixva, g1ra, ddh, ls1, dpsi1, ls2, psi2, g2dp, lie;

   // clip marks, gathered per time slot
   logic [31:5] flag_at;
   logic        sat_ff [6:31];

   cbc_rsp_type rsp_data_ff;
   logic        rsp_strobe_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // widened register values
   assign dmin_q = {17'd0, clr_ff, 16'd0};
   assign im_q   = {17'd0, im_ff, 16'd0};
   assign g1_q   = {17'd0, g1_ff, 16'd0};
   assign g2_q   = {17'd0, g2_ff, 16'd0};
   assign g1x2_q = {16'd0, g1_ff, 17'd0};   // doubling is exact here
   assign im2_q  = {16'd0, im_ff, 17'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_x_ff <= '0;
         obs_y_ff <= '0;
         obs_z_ff <= '0;
         clr_ff   <= 31'd65536;
         g1_ff    <= 31'd65536;
         g2_ff    <= 31'd65536;
         im_ff    <= 31'd65536;
         cyl_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OBS_X:    obs_x_ff <= csr_data;
            CSR_OBS_Y:    obs_y_ff <= csr_data;
            CSR_OBS_Z:    obs_z_ff <= csr_data;
            CSR_CLEAR:    clr_ff   <= csr_data[30:0];
            CSR_GAIN_1:   g1_ff    <= csr_data[30:0];
            CSR_GAIN_2:   g2_ff    <= csr_data[30:0];
            CSR_INV_MASS: im_ff    <= csr_data[30:0];
            CSR_CYL:      cyl_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // entry: Q16.16 to Q32.32, cylinder drops the vertical parts of rel and vp
   always_comb begin
      dx_in = {req_data.pos_x[31], req_data.pos_x} - {obs_x_ff[31], obs_x_ff};
      dy_in = {req_data.pos_y[31], req_data.pos_y} - {obs_y_ff[31], obs_y_ff};
      dz_in = {req_data.pos_z[31], req_data.pos_z} - {obs_z_ff[31], obs_z_ff};
      rel_in[0] = {{15{dx_in[32]}}, dx_in, 16'd0};
      rel_in[1] = {{15{dy_in[32]}}, dy_in, 16'd0};
      rel_in[2] = cyl_ff ? 64'd0 : {{15{dz_in[32]}}, dz_in, 16'd0};
      vf_in[0]  = {{16{req_data.vel_x[31]}}, req_data.vel_x, 16'd0};
      vf_in[1]  = {{16{req_data.vel_y[31]}}, req_data.vel_y, 16'd0};
      vf_in[2]  = {{16{req_data.vel_z[31]}}, req_data.vel_z, 16'd0};
      vp_in[0]  = vf_in[0];
      vp_in[1]  = vf_in[1];
      vp_in[2]  = cyl_ff ? 64'd0 : vf_in[2];
      row_in[0] = req_data.rot_row0;
      row_in[1] = req_data.rot_row1;
      row_in[2] = req_data.rot_row2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 32; k++) vld_ff[k] <= 1'b0;
         for (int k = 6; k < 32; k++) sat_ff[k] <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int k = 1; k < 32; k++) vld_ff[k] <= vld_ff[k-1];
         sat_ff[6] <= flag_at[5];
         for (int k = 7; k < 32; k++) sat_ff[k] <= sat_ff[k-1] | flag_at[k-1];
         rsp_strobe_ff <= vld_ff[31];
      end
   end

   // payload pipe, no reset
   always_ff @(posedge clock) begin
      rel_ff <= rel_in;
      vf_ff  <= vf_in;
      vp_ff  <= vp_in;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rot_ff[i][j] <= {{30{row_in[i][16*j+15]}}, row_in[i][16*j +: 16], 18'd0};
      thr_ff <= {17'd0, req_data.thrust, 16'd0};

      rel_d_ff[1] <= rel_ff;
      vp_d_ff[1]  <= vp_ff;
      for (int k = 2; k <= 11; k++) begin
         rel_d_ff[k] <= rel_d_ff[k-1];
         vp_d_ff[k]  <= vp_d_ff[k-1];
      end
      for (int i = 0; i < 3; i++) rc2_d_ff[1][i] <= rot_ff[i][2];
      for (int k = 2; k <= 5; k++) rc2_d_ff[k] <= rc2_d_ff[k-1];
      dd_d_ff[6] <= dd.value;
      dd_d_ff[7] <= dd_d_ff[6];
      tm_d_ff[6] <= tm.value;
      tm_d_ff[7] <= tm_d_ff[6];
      acc_d_ff[0] <= acc[0].value;
      acc_d_ff[1] <= acc[1].value;
      dh_d_ff     <= dh.value;
      g1dh_d_ff[18] <= g1dh.value;
      for (int k = 19; k <= 24; k++) g1dh_d_ff[k] <= g1dh_d_ff[k-1];
      twovv_d_ff[13] <= twovv.value;
      g1vv_d_ff[13]  <= g1vv.value;
      for (int k = 14; k <= 23; k++) begin
         twovv_d_ff[k] <= twovv_d_ff[k-1];
         g1vv_d_ff[k]  <= g1vv_d_ff[k-1];
      end
      g1ra_d_ff <= g1ra.value;
      g2p1_d_ff[20] <= g2p1.value;
      for (int k = 21; k <= 25; k++) g2p1_d_ff[k] <= g2p1_d_ff[k-1];
      ls2_d_ff[26] <= ls2.value;
      for (int k = 27; k <= 30; k++) ls2_d_ff[k] <= ls2_d_ff[k-1];

      // align finished terms with the lie term
      h_d_ff[9] <= h.value;
      for (int k = 10; k <= 31; k++) h_d_ff[k] <= h_d_ff[k-1];
      psi1_d_ff[15] <= psi1.value;
      for (int k = 16; k <= 31; k++) psi1_d_ff[k] <= psi1_d_ff[k-1];
      psi2_d_ff[27] <= psi2.value;
      for (int k = 28; k <= 31; k++) psi2_d_ff[k] <= psi2_d_ff[k-1];
      ctau_d_ff[13] <= ctau.value;
      cw1_d_ff[13]  <= cw1.value;
      cw2_d_ff[13]  <= cw2.value;
      for (int k = 14; k <= 31; k++) begin
         ctau_d_ff[k] <= ctau_d_ff[k-1];
         cw1_d_ff[k]  <= cw1_d_ff[k-1];
         cw2_d_ff[k]  <= cw2_d_ff[k-1];
      end
      for (int j = 0; j < 3; j++) rt_d_ff[8][j] <= rts[j].value;
      for (int k = 9; k <= 31; k++) rt_d_ff[k] <= rt_d_ff[k-1];

      rsp_data_ff.barrier_value    <= h_d_ff[31];
      rsp_data_ff.psi_one          <= psi1_d_ff[31];
      rsp_data_ff.psi_two          <= psi2_d_ff[31];
      rsp_data_ff.lie_drift        <= lie.value;
      rsp_data_ff.coef_thrust_rate <= ctau_d_ff[31];
      rsp_data_ff.coef_rate_one    <= cw1_d_ff[31];
      rsp_data_ff.coef_rate_two    <= cw2_d_ff[31];
      rsp_data_ff.body_rel_x       <= rt_d_ff[31][0];
      rsp_data_ff.body_rel_y       <= rt_d_ff[31][1];
      rsp_data_ff.body_rel_z       <= rt_d_ff[31][2];
      rsp_data_ff.saturated        <= sat_ff[31] | flag_at[31];
   end

   assign accv[0] = acc_d_ff[0];
   assign accv[1] = acc_d_ff[1];
   assign accv[2] = acc2s.value;
   assign k2tm    = {tm_d_ff[7][62:0], 1'b0};   // thrust*inv_mass < 2^62, no clip

   // first products, t0 -> t5
   for (genvar gi = 0; gi < 3; gi++) begin : g_axis
      cbc_smul u_rr (.clock, .op_a(rel_ff[gi]), .op_b(rel_ff[gi]), .product(rr[gi]));
      cbc_smul u_rv (.clock, .op_a(rel_ff[gi]), .op_b(vf_ff[gi]), .product(rv[gi]));
      cbc_smul u_vv (.clock, .op_a(vp_ff[gi]), .op_b(vp_ff[gi]), .product(vv[gi]));
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         cbc_smul u_rt (.clock, .op_a(rot_ff[gi][gj]), .op_b(rel_ff[gi]),
                        .product(rtp[gj][gi]));
      end
      // acceleration, t5 -> t10
      cbc_smul u_acc (.clock, .op_a(tm.value), .op_b(rc2_d_ff[5][gi]), .product(acc[gi]));
      // rel.a and v.a terms, t11 -> t16
      cbc_smul u_ra (.clock, .op_a(rel_d_ff[11][gi]), .op_b(accv[gi]), .product(rap[gi]));
      cbc_smul u_va (.clock, .op_a(vp_d_ff[11][gi]), .op_b(accv[gi]), .product(vap[gi]));
      // body frame, t5 -> t7
      cbc_dot3 u_rts (.clock, .term_x(rtp[gi][0].value), .term_y(rtp[gi][1].value),
                      .term_z(rtp[gi][2].value), .sum(rts[gi]));
   end

   cbc_smul u_dd (.clock, .op_a(dmin_q), .op_b(dmin_q), .product(dd));
   cbc_smul u_tm (.clock, .op_a(thr_ff), .op_b(im_q), .product(tm));

   cbc_dot3 u_rrs (.clock, .term_x(rr[0].value), .term_y(rr[1].value),
                   .term_z(rr[2].value), .sum(rrs));
   cbc_dot3 u_rvs (.clock, .term_x(rv[0].value), .term_y(rv[1].value),
                   .term_z(rv[2].value), .sum(rvs));
   cbc_dot3 u_vvs (.clock, .term_x(vv[0].value), .term_y(vv[1].value),
                   .term_z(vv[2].value), .sum(vvs));

   // h at t8, a_z at t11
   cbc_sadd u_h    (.clock, .op_a(rrs.value), .op_b(dd_d_ff[7]), .subtract(1'b1), .sum(h));
   cbc_sadd u_acc2 (.clock, .op_a(acc[2].value), .op_b(Q_GRAVITY), .subtract(1'b1),
                    .sum(acc2s));

   // t7 -> t12
   cbc_smul u_dh    (.clock, .op_a(Q_TWO), .op_b(rvs.value), .product(dh));
   cbc_smul u_twovv (.clock, .op_a(Q_TWO), .op_b(vvs.value), .product(twovv));
   cbc_smul u_g1vv  (.clock, .op_a(g1x2_q), .op_b(vvs.value), .product(g1vv));
   cbc_smul u_ctau  (.clock, .op_a(im2_q), .op_b(rts[2].value), .product(ctau));
   cbc_smul u_cw1   (.clock, .op_a(k2tm), .op_b(rts[1].value), .product(cw1));
   cbc_smul u_cw2   (.clock, .op_a(k2tm), .op_b(rts[0].value), .product(cw2));

   // psi one: g1*h t8 -> t13, sum t14
   cbc_smul u_g1h  (.clock, .op_a(g1_q), .op_b(h.value), .product(g1h));
   cbc_sadd u_psi1 (.clock, .op_a(dh_d_ff), .op_b(g1h.value), .subtract(1'b0), .sum(psi1));
   cbc_smul u_g1dh (.clock, .op_a(g1_q), .op_b(dh.value), .product(g1dh));
   cbc_smul u_g2p1 (.clock, .op_a(g2_q), .op_b(psi1.value), .product(g2p1));

   // rel.a and v.a sums at t18
   cbc_dot3 u_ras (.clock, .term_x(rap[0].value), .term_y(rap[1].value),
                   .term_z(rap[2].value), .sum(ras));
   cbc_dot3 u_vas (.clock, .term_x(vap[0].value), .term_y(vap[1].value),
                   .term_z(vap[2].value), .sum(vas));

   // t18 -> t23
   cbc_smul u_twora (.clock, .op_a(Q_TWO), .op_b(ras.value), .product(twora));
   cbc_smul u_sixva (.clock, .op_a(Q_SIX), .op_b(vas.value), .product(sixva));
   cbc_smul u_g1ra  (.clock, .op_a(g1x2_q), .op_b(ras.value), .product(g1ra));

   cbc_sadd u_ddh   (.clock, .op_a(twovv_d_ff[23]), .op_b(twora.value), .subtract(1'b0),
                     .sum(ddh));
   cbc_sadd u_ls1   (.clock, .op_a(sixva.value), .op_b(g1vv_d_ff[23]), .subtract(1'b0),
                     .sum(ls1));
   cbc_sadd u_dpsi1 (.clock, .op_a(ddh.value), .op_b(g1dh_d_ff[24]), .subtract(1'b0),
                     .sum(dpsi1));
   cbc_sadd u_ls2   (.clock, .op_a(ls1.value), .op_b(g1ra_d_ff), .subtract(1'b0),
                     .sum(ls2));
   cbc_sadd u_psi2  (.clock, .op_a(dpsi1.value), .op_b(g2p1_d_ff[25]), .subtract(1'b0),
                     .sum(psi2));
   cbc_smul u_g2dp  (.clock, .op_a(g2_q), .op_b(dpsi1.value), .product(g2dp));
   cbc_sadd u_lie   (.clock, .op_a(ls2_d_ff[30]), .op_b(g2dp.value), .subtract(1'b0),
                     .sum(lie));

   // clip marks by the time their result appears
   always_comb begin
      flag_at = '0;
      for (int i = 0; i < 3; i++) begin
         flag_at[5]  = flag_at[5] | rr[i].clip | rv[i].clip | vv[i].clip;
         flag_at[7]  = flag_at[7] | rts[i].clip;
         flag_at[10] = flag_at[10] | acc[i].clip;
         flag_at[16] = flag_at[16] | rap[i].clip | vap[i].clip;
         for (int j = 0; j < 3; j++) flag_at[5] = flag_at[5] | rtp[i][j].clip;
      end
      flag_at[5]  = flag_at[5] | dd.clip | tm.clip;
      flag_at[7]  = flag_at[7] | rrs.clip | rvs.clip | vvs.clip;
      flag_at[8]  = h.clip;
      flag_at[11] = acc2s.clip;
      flag_at[12] = dh.clip | twovv.clip | g1vv.clip | cw1.clip | cw2.clip | ctau.clip;
      flag_at[13] = g1h.clip;
      flag_at[14] = psi1.clip;
      flag_at[17] = g1dh.clip;
      flag_at[18] = ras.clip | vas.clip;
      flag_at[19] = g2p1.clip;
      flag_at[23] = twora.clip | sixva.clip | g1ra.clip;
      flag_at[24] = ddh.clip | ls1.clip;
      flag_at[25] = dpsi1.clip | ls2.clip;
      flag_at[26] = psi2.clip;
      flag_at[30] = g2dp.clip;
      flag_at[31] = lie.clip;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef ASSERT_OFF
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LAT))
      else $error("result strobe without a matching start transfer");

   a_no_lost: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LAT rsp_strobe)
      else $error("start transfer produced no result");
`endif

endmodule

FILE: rtl/cbc_smul.sv
// Five-stage saturating Q32.32 multiplier built from four 32x32 partial products.
module cbc_smul import cbc_pkg::*; (
   input  logic        clock,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output cbc_num_type product
);

   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [63:0] ua_ff, ub_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [33:0] mid_ff;
   logic [63:0] hip_ff;
   logic [63:0] hi_in;
   logic        over_ff;
   logic [63:0] mag_ff;
   logic        big_in;
   logic [63:0] lim_in, sel_in;
   cbc_num_type product_ff;

   always_comb begin
      hi_in  = hip_ff + {62'd0, mid_ff[33:32]};
      big_in = over_ff | (mag_ff[63] & (~neg4_ff | (|mag_ff[62:0])));
      lim_in = neg4_ff ? Q_MIN : Q_MAX;
      sel_in = big_in ? lim_in : mag_ff;
   end

   always_ff @(posedge clock) begin
      // magnitudes
      neg1_ff <= op_a[63] ^ op_b[63];
      ua_ff   <= op_a[63] ? (~op_a + 64'd1) : op_a;
      ub_ff   <= op_b[63] ? (~op_b + 64'd1) : op_b;
      // partial products
      neg2_ff <= neg1_ff;
      p00_ff  <= ua_ff[31:0]  * ub_ff[31:0];
      p01_ff  <= ua_ff[31:0]  * ub_ff[63:32];
      p10_ff  <= ua_ff[63:32] * ub_ff[31:0];
      p11_ff  <= ua_ff[63:32] * ub_ff[63:32];
      // column sums
      neg3_ff <= neg2_ff;
      mid_ff  <= {2'd0, p00_ff[63:32]} + {2'd0, p01_ff[31:0]} + {2'd0, p10_ff[31:0]};
      hip_ff  <= p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]};
      // carry in, take bits 95:32
      neg4_ff <= neg3_ff;
      over_ff <= |hi_in[63:32];
      mag_ff  <= {hi_in[31:0], mid_ff[31:0]};
      // clip and sign
      product_ff.clip  <= big_in;
      product_ff.value <= neg4_ff ? (~sel_in + 64'd1) : sel_in;
   end

   assign product = product_ff;

endmodule

FILE: rtl/cbc_sadd.sv
// Registered saturating 64-bit add or subtract.
module cbc_sadd import cbc_pkg::*; (
   input  logic        clock,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic        subtract,
   output cbc_num_type sum
);

   logic [64:0] raw_in;
   logic        ovf_in;
   cbc_num_type sum_ff;

   always_comb begin
      raw_in = subtract ? ({op_a[63], op_a} - {op_b[63], op_b})
                        : ({op_a[63], op_a} + {op_b[63], op_b});
      ovf_in = raw_in[64] ^ raw_in[63];
   end

   always_ff @(posedge clock) begin
      sum_ff.clip  <= ovf_in;
      sum_ff.value <= ovf_in ? (raw_in[64] ? Q_MIN : Q_MAX) : raw_in[63:0];
   end

   assign sum = sum_ff;

endmodule

FILE: rtl/cbc_dot3.sv
// Two-stage saturating sum of three terms, x then y then z.
module cbc_dot3 import cbc_pkg::*; (
   input  logic        clock,
   input  logic [63:0] term_x,
   input  logic [63:0] term_y,
   input  logic [63:0] term_z,
   output cbc_num_type sum
);

   cbc_num_type part, total;
   logic [63:0] z_ff;
   logic        c1_ff;

   cbc_sadd u_add_xy (.clock, .op_a(term_x), .op_b(term_y), .subtract(1'b0), .sum(part));
   cbc_sadd u_add_z  (.clock, .op_a(part.value), .op_b(z_ff), .subtract(1'b0), .sum(total));

   always_ff @(posedge clock) begin
      z_ff  <= term_z;
      c1_ff <= part.clip;
   end

   assign sum = '{value: total.value, clip: total.clip | c1_ff};

endmodule

FILE: dv/cbc_checker.sv
// Checker for the collision barrier chain: watches the channels, predicts each result and compares.
module cbc_checker import cbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  cbc_req_type req_data,
   input  logic        rsp_strobe,
   input  cbc_rsp_type rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies widened to 64 bits: obstacle in Q16.16; clearance, gains and inverse mass in Q32.32
   logic signed [63:0] obs_x, obs_y, obs_z, clearance, gain1, gain2, inv_mass;
   logic               cyl;
   logic               clipped;
   cbc_rsp_type        barrier_queue[$];

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         clipped = 1'b1; return Q_MAX;
      end
      if (s < -65'sh0_8000_0000_0000_0000) begin
         clipped = 1'b1; return Q_MIN;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         clipped = 1'b1; return Q_MAX;
      end
      if (s < -65'sh0_8000_0000_0000_0000) begin
         clipped = 1'b1; return Q_MIN;
      end
      return s[63:0];
   endfunction

   // exact product, shift by 32 truncating toward zero, then clip
   function automatic logic signed [63:0] sat_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = 128'(a) * 128'(b);
      if (p < 0) q = -((-p) >>> 32);
      else q = p >>> 32;
      if (q > 128'sh7FFF_FFFF_FFFF_FFFF) begin
         clipped = 1'b1; return Q_MAX;
      end
      if (q < -128'sh8000_0000_0000_0000) begin
         clipped = 1'b1; return Q_MIN;
      end
      return q[63:0];
   endfunction

   function automatic logic signed [63:0] dot(logic signed [63:0] a0, logic signed [63:0] a1,
         logic signed [63:0] a2, logic signed [63:0] b0, logic signed [63:0] b1,
         logic signed [63:0] b2);
      logic signed [63:0] m0, m1, m2;
      m0 = sat_mul(a0, b0);
      m1 = sat_mul(a1, b1);
      m2 = sat_mul(a2, b2);
      return sat_add(sat_add(m0, m1), m2);
   endfunction

   function automatic cbc_rsp_type predict_barrier(cbc_req_type r);
      logic signed [63:0] rel[3], vf[3], vp[3], acc[3], bt[3], rot[3][3];
      logic signed [63:0] thr, h, dh, tm, vv, ra, va, ddh, psi1, dpsi1, psi2;
      logic signed [63:0] k2tm, g1x2, lie, t0, t1, t2;
      logic [47:0] rows[3];
      cbc_rsp_type o;
      clipped = 1'b0;
      rel[0] = (64'(r.pos_x) - obs_x) <<< 16;
      rel[1] = (64'(r.pos_y) - obs_y) <<< 16;
      rel[2] = (64'(r.pos_z) - obs_z) <<< 16;
      vf[0] = 64'(r.vel_x) <<< 16;
      vf[1] = 64'(r.vel_y) <<< 16;
      vf[2] = 64'(r.vel_z) <<< 16;
      vp = vf;
      rows[0] = r.rot_row0; rows[1] = r.rot_row1; rows[2] = r.rot_row2;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rot[i][j] = 64'(signed'(rows[i][16*j +: 16])) <<< 18;
      if (cyl) begin
         rel[2] = 0; vp[2] = 0;
      end
      thr = 64'({1'b0, r.thrust}) <<< 16;
      h = sat_sub(dot(rel[0], rel[1], rel[2], rel[0], rel[1], rel[2]),
                  sat_mul(clearance, clearance));
      dh = sat_mul(Q_TWO, dot(rel[0], rel[1], rel[2], vf[0], vf[1], vf[2]));
      tm = sat_mul(thr, inv_mass);
      for (int i = 0; i < 3; i++) acc[i] = sat_mul(tm, rot[i][2]);
      acc[2] = sat_sub(acc[2], Q_GRAVITY);
      vv = dot(vp[0], vp[1], vp[2], vp[0], vp[1], vp[2]);
      ra = dot(rel[0], rel[1], rel[2], acc[0], acc[1], acc[2]);
      va = dot(vp[0], vp[1], vp[2], acc[0], acc[1], acc[2]);
      t0 = sat_mul(Q_TWO, vv);
      ddh = sat_add(t0, sat_mul(Q_TWO, ra));
      psi1 = sat_add(dh, sat_mul(gain1, h));
      dpsi1 = sat_add(ddh, sat_mul(gain1, dh));
      psi2 = sat_add(dpsi1, sat_mul(gain2, psi1));
      for (int j = 0; j < 3; j++) begin
         t0 = sat_mul(rot[0][j], rel[0]);
         t1 = sat_mul(rot[1][j], rel[1]);
         bt[j] = sat_add(sat_add(t0, t1), sat_mul(rot[2][j], rel[2]));
      end
      o.coef_thrust_rate = sat_mul(sat_mul(Q_TWO, inv_mass), bt[2]);
      k2tm = sat_mul(Q_TWO, tm);
      o.coef_rate_two = sat_mul(k2tm, bt[0]);
      o.coef_rate_one = sat_mul(k2tm, bt[1]);
      g1x2 = sat_mul(Q_TWO, gain1);
      t0 = sat_mul(Q_SIX, va);
      t1 = sat_mul(g1x2, vv);
      t2 = sat_add(t0, t1);
      t2 = sat_add(t2, sat_mul(g1x2, ra));
      lie = sat_add(t2, sat_mul(gain2, dpsi1));
      o.barrier_value = h;
      o.psi_one = psi1;
      o.psi_two = psi2;
      o.lie_drift = lie;
      o.body_rel_x = bt[0];
      o.body_rel_y = bt[1];
      o.body_rel_z = bt[2];
      o.saturated = clipped;
      return o;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cbc_rsp_type want;
      if (reset) begin
         obs_x <= 0; obs_y <= 0; obs_z <= 0;
         clearance <= 64'd65536 <<< 16;
         gain1 <= 64'd65536 <<< 16;
         gain2 <= 64'd65536 <<< 16;
         inv_mass <= 64'd65536 <<< 16;
         cyl <= 1'b0;
         barrier_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OBS_X:    obs_x <= 64'(signed'(csr_data));
               CSR_OBS_Y:    obs_y <= 64'(signed'(csr_data));
               CSR_OBS_Z:    obs_z <= 64'(signed'(csr_data));
               CSR_CLEAR:    clearance <= 64'(csr_data[30:0]) <<< 16;
               CSR_GAIN_1:   gain1 <= 64'(csr_data[30:0]) <<< 16;
               CSR_GAIN_2:   gain2 <= 64'(csr_data[30:0]) <<< 16;
               CSR_INV_MASS: inv_mass <= 64'(csr_data[30:0]) <<< 16;
               CSR_CYL:      cyl <= csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) barrier_queue.push_back(predict_barrier(req_data));
         if (rsp_strobe) begin
            if (barrier_queue.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               want = barrier_queue.pop_front();
               check_field("barrier_value", want.barrier_value, rsp_data.barrier_value);
               check_field("psi_one", want.psi_one, rsp_data.psi_one);
               check_field("psi_two", want.psi_two, rsp_data.psi_two);
               check_field("lie_drift", want.lie_drift, rsp_data.lie_drift);
               check_field("coef_thrust_rate", want.coef_thrust_rate,
                           rsp_data.coef_thrust_rate);
               check_field("coef_rate_one", want.coef_rate_one, rsp_data.coef_rate_one);
               check_field("coef_rate_two", want.coef_rate_two, rsp_data.coef_rate_two);
               check_field("body_rel_x", want.body_rel_x, rsp_data.body_rel_x);
               check_field("body_rel_y", want.body_rel_y, rsp_data.body_rel_y);
               check_field("body_rel_z", want.body_rel_z, rsp_data.body_rel_z);
               check_field("saturated", 64'(want.saturated), 64'(rsp_data.saturated));
            end
         end
      end
      pending <= barrier_queue.size();
   end

endmodule

FILE: dv/tb_collision_barrier_chain_core.sv
// Testbench top for the collision barrier chain: stimulus, register phases and verdict.
module tb_collision_barrier_chain_core;
   import cbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cbc_req_type req_data = '0;
   logic        rsp_strobe;
   cbc_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_OBS_X;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   collision_barrier_chain_core dut (.*);

   cbc_checker checker_i (.*);

   // hard stop well beyond the slowest correct run
   initial begin
      #2ms;
      $display("tb_collision_barrier_chain_core: errors");
      $finish;
   end

   // one register write; the block is idle whenever this is called
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random Q1.14 element, biased toward the unit range, with full-range extremes
   function automatic logic [15:0] rot_elem();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h4000;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // coordinates: mostly modest metres, sometimes raw full range to push clipping
   function automatic logic [31:0] coord();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000);
      endcase
   endfunction

   function automatic cbc_req_type random_state();
      cbc_req_type r;
      r.pos_x = coord(); r.pos_y = coord(); r.pos_z = coord();
      r.vel_x = coord(); r.vel_y = coord(); r.vel_z = coord();
      r.thrust = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h0020_0000));
      r.rot_row0 = {rot_elem(), rot_elem(), rot_elem()};
      r.rot_row1 = {rot_elem(), rot_elem(), rot_elem()};
      r.rot_row2 = {rot_elem(), rot_elem(), rot_elem()};
      return r;
   endfunction

   // one transfer; start stays high into the next call when back to back,
   // otherwise it is dropped before the task returns
   task automatic send_state(cbc_req_type r, bit hold);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (!hold) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // bursts of random length, back to back inside each burst, with random extra gaps between bursts, sometimes none
   task automatic send_random(int count);
      int left, burst, gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         for (int k = 0; k < burst; k++) send_state(random_state(), k != burst - 1);
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
   endtask

   // let the pipe drain before registers change
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (RSP_LAT + 4) @(posedge clock);
   endtask

   task automatic directed_set();
      cbc_req_type r;
      r = '0;
      send_state(r, 1'b0);                       // all zero: gravity only
      r.rot_row0 = 48'h0000_0000_4000;           // identity rotation
      r.rot_row1 = 48'h0000_4000_0000;
      r.rot_row2 = 48'h4000_0000_0000;
      r.pos_x = 32'sh0002_0000; r.vel_y = 32'sh0001_0000; r.thrust = 31'h0009_CF5C;
      send_state(r, 1'b1);
      r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000; r.pos_z = 32'h7FFF_FFFF;
      send_state(r, 1'b1);                       // extreme position, sum of squares clips with obstacle at 0
      r.vel_x = 32'h8000_0000; r.vel_y = 32'h7FFF_FFFF; r.vel_z = 32'h8000_0000;
      r.thrust = 31'h7FFF_FFFF;
      send_state(r, 1'b1);
      r.rot_row0 = '1; r.rot_row1 = 48'h8000_8000_8000; r.rot_row2 = 48'h7FFF_7FFF_7FFF;
      send_state(r, 1'b1);                       // rotation extremes
      r = '0;
      r.rot_row2 = 48'h8000_0000_0000; r.thrust = 31'h0010_0000; r.pos_z = 32'sh0000_8000;
      send_state(r, 1'b1);                       // inverted vehicle
      r = '1;
      send_state(r, 1'b0);                       // every bit set
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults first
      directed_set();
      send_random(150);
      drain();

      // extremes of every register, including zero reciprocal mass and cylinder mode
      write_reg(CSR_OBS_X, 32'h7FFF_FFFF);
      write_reg(CSR_OBS_Y, 32'h8000_0000);
      write_reg(CSR_OBS_Z, 32'h7FFF_FFFF);
      write_reg(CSR_CLEAR, 32'hFFFF_FFFF);
      write_reg(CSR_GAIN_1, 32'h7FFF_FFFF);
      write_reg(CSR_GAIN_2, 32'h0000_0000);
      write_reg(CSR_INV_MASS, 32'h0000_0000);
      write_reg(CSR_CYL, 32'hFFFF_FFFF);
      directed_set();
      send_random(150);
      drain();

      write_reg(CSR_OBS_X, 32'h8000_0000);
      write_reg(CSR_OBS_Y, 32'h7FFF_FFFF);
      write_reg(CSR_OBS_Z, 32'h8000_0000);
      write_reg(CSR_CLEAR, 32'h0000_0000);
      write_reg(CSR_GAIN_1, 32'h0000_0000);
      write_reg(CSR_GAIN_2, 32'h7FFF_FFFF);
      write_reg(CSR_INV_MASS, 32'h7FFF_FFFF);
      write_reg(CSR_CYL, 32'h0000_0000);
      send_random(150);
      drain();

      // random realistic settings
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_OBS_X, 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000));
         write_reg(CSR_OBS_Y, 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000));
         write_reg(CSR_OBS_Z, (p == 5) ? $urandom() : 32'($urandom_range(0, 32'h0008_0000)));
         write_reg(CSR_CLEAR, $urandom_range(0, 32'h0004_0000) | (p == 4 ? 32'h8000_0000 : 0));
         write_reg(CSR_GAIN_1, $urandom_range(0, 32'h0008_0000));
         write_reg(CSR_GAIN_2, $urandom_range(0, 32'h0008_0000));
         write_reg(CSR_INV_MASS, $urandom_range(1, 32'h0004_0000));
         write_reg(CSR_CYL, {$urandom_range(0, 1)});
         send_random(240);
         drain();
      end

      if (fail_count == 0)
         $display("tb_collision_barrier_chain_core: clean");
      else
         $display("tb_collision_barrier_chain_core: errors");
      $finish;
   end
endmodule
